/* sv/gop_pkg.sv */
// ----------------------------------------------------------------------------
// gop_pkg
// Shared types and constants of the grain orientation parameter unit.
// ----------------------------------------------------------------------------
package gop_pkg;

    localparam int FRACTION_BITS          = 16;
    localparam int DEFAULT_MAX_NEIGHBOURS = 255;
    localparam int QUEUE_DEPTH            = 4;

    localparam int VALUE_W   = FRACTION_BITS + 2;
    localparam int TERM_W    = FRACTION_BITS + 2;
    localparam int SUM_W     = 26;
    localparam int MEAN_W    = SUM_W + 1;
    localparam int RATIO_W   = 30;
    localparam int ROUND_SH  = 2 * RATIO_W - FRACTION_BITS;
    localparam int PROJ_W    = 50;
    localparam int CFG_W     = 48;

    localparam logic [63:0] NEAR_ZERO_Q60 = 64'd11529215047;

    // register indexes
    localparam logic [2:0] REG_BOX_X     = 3'd0;
    localparam logic [2:0] REG_BOX_Y     = 3'd1;
    localparam logic [2:0] REG_BOX_Z     = 3'd2;
    localparam logic [2:0] REG_X_COEFFS  = 3'd3;
    localparam logic [2:0] REG_Y_COEFFS  = 3'd4;
    localparam logic [2:0] REG_GRAIN_CUT = 3'd5;

    localparam logic [30:0]      BOX_RESET      = 31'd65536;
    localparam logic [47:0]      X_COEFFS_RESET = 48'd16384;
    localparam logic [47:0]      Y_COEFFS_RESET = 48'd1073741824;
    localparam logic [VALUE_W-1:0] CUT_RESET    = VALUE_W'(65536);

    typedef struct packed {
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] offset_z;
        logic        is_neighbour;
        logic        last_of_atom;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] orientation_value;
        logic               grain_id;
        logic [7:0]         neighbour_total;
    } result_t;

    // offsets after the minimum image
    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic        is_neighbour;
        logic        last_of_atom;
    } work_t;

endpackage

/* sv/gop_fifo.sv */
// ----------------------------------------------------------------------------
// gop_fifo
// Small register queue, first in first out, data shown while not empty.
// ----------------------------------------------------------------------------
module gop_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gop_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/gop_front.sv */
// ----------------------------------------------------------------------------
// gop_front
// Takes requests, applies the periodic minimum image and drops empty markers.
// ----------------------------------------------------------------------------
module gop_front (
    input  logic                push,
    input  logic                q_full,
    input  gop_pkg::item_t      item,
    input  logic [30:0]         box_x,
    input  logic [30:0]         box_y,
    input  logic [30:0]         box_z,
    output logic                q_wr,
    output gop_pkg::work_t      q_work
);

    function automatic logic [31:0] min_image(input logic [31:0] r, input logic [30:0] l);
        logic signed [32:0] r2;
        logic signed [32:0] ls;
        logic signed [32:0] rs;
        logic signed [32:0] res;
        r2 = {r, 1'b0};
        ls = {2'b00, l};
        rs = {r[31], r};
        if (r2 >= ls)
        begin
            res = rs - ls;
        end
        else if (r2 <= -ls)
        begin
            res = rs + ls;
        end
        else
        begin
            res = rs;
        end
        return res[31:0];
    endfunction

    always_comb
    begin
        q_work.rx           = min_image(item.offset_x, box_x);
        q_work.ry           = min_image(item.offset_y, box_y);
        q_work.rz           = min_image(item.offset_z, box_z);
        q_work.is_neighbour = item.is_neighbour;
        q_work.last_of_atom = item.last_of_atom;
        // a marker that is neither neighbour nor last changes nothing
        q_wr = push && !q_full && (item.is_neighbour || item.last_of_atom);
    end

endmodule

/* sv/gop_back.sv */
// ----------------------------------------------------------------------------
// gop_back
// Sequencer: projection, c^2 division, term, accumulation and the mean.
// ----------------------------------------------------------------------------
module gop_back #(
    parameter int MAX_NEIGHBOURS = gop_pkg::DEFAULT_MAX_NEIGHBOURS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  gop_pkg::work_t                q_work,
    output logic                          q_rd,
    input  logic [47:0]                   x_coeffs,
    input  logic [47:0]                   y_coeffs,
    input  logic [gop_pkg::VALUE_W-1:0]   grain_cut,
    input  logic                          out_full,
    output logic                          out_wr,
    output gop_pkg::result_t              out_result
);

    localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);
    localparam int VW    = gop_pkg::VALUE_W;
    localparam int PW    = gop_pkg::PROJ_W;
    localparam int TW    = gop_pkg::TERM_W;
    localparam int SW    = gop_pkg::SUM_W;
    localparam int MW    = gop_pkg::MEAN_W;
    localparam int RW    = gop_pkg::RATIO_W;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_PROJ = 16'h0002,
        S_ABS  = 16'h0004,
        S_NORM = 16'h0008,
        S_SQA  = 16'h0010,
        S_SQB  = 16'h0020,
        S_CHK  = 16'h0040,
        S_DIV  = 16'h0080,
        S_U    = 16'h0100,
        S_USQ  = 16'h0200,
        S_PRD  = 16'h0400,
        S_RND  = 16'h0800,
        S_ACC  = 16'h1000,
        S_FIN  = 16'h2000,
        S_MDIV = 16'h4000,
        S_EMIT = 16'h8000
    } state_t;

    state_t                state_reg, state_next;
    logic [4:0]            iter_reg, iter_next;
    gop_pkg::work_t        work_reg, work_next;
    logic signed [PW-1:0]  px_reg, px_next, py_reg, py_next;
    logic [PW-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic                  shifted_reg, shifted_next;
    logic [61:0]           a2_reg, a2_next;
    logic [62:0]           den_reg, den_next;
    logic [63:0]           rem_reg, rem_next;
    logic [RW:0]           t_reg, t_next;
    logic                  eq_reg, eq_next;
    logic [31:0]           u_reg, u_next;
    logic [33:0]           u2_reg, u2_next;
    logic [64:0]           prod_reg, prod_next;
    logic [TW-1:0]         term_reg, term_next;
    logic [SW-1:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VW-1:0]         prev_reg, prev_next;
    logic [MW-1:0]         mq_reg, mq_next;
    logic [CNT_W-1:0]      mrem_reg, mrem_next;
    logic [VW-1:0]         value_reg, value_next;

    logic signed [15:0]    coef;
    logic signed [31:0]    rsel;
    logic signed [47:0]    mprod;
    logic [64:0]           rem_sh;
    logic [64:0]           prod_rnd;
    logic [SW:0]           sum_wide;
    logic [CNT_W:0]        mrem_sh;
    logic [RW:0]           t_fin;
    logic [63:0]           usq;

    // one projection product a cycle: px from steps 0..2, py from 3..5
    always_comb
    begin
        unique case (iter_reg[2:0])
            3'd0:    begin coef = x_coeffs[15:0];  rsel = work_reg.rx; end
            3'd1:    begin coef = x_coeffs[31:16]; rsel = work_reg.ry; end
            3'd2:    begin coef = x_coeffs[47:32]; rsel = work_reg.rz; end
            3'd3:    begin coef = y_coeffs[15:0];  rsel = work_reg.rx; end
            3'd4:    begin coef = y_coeffs[31:16]; rsel = work_reg.ry; end
            3'd5:    begin coef = y_coeffs[47:32]; rsel = work_reg.rz; end
            default: begin coef = '0;              rsel = '0;          end
        endcase
        mprod = coef * rsel;
    end

    always_comb
    begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        work_next    = work_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        shifted_next = shifted_reg;
        a2_next      = a2_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        t_next       = t_reg;
        eq_next      = eq_reg;
        u_next       = u_reg;
        u2_next      = u2_reg;
        prod_next    = prod_reg;
        term_next    = term_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        mq_next      = mq_reg;
        mrem_next    = mrem_reg;
        value_next   = value_reg;
        q_rd         = 1'b0;
        out_wr       = 1'b0;
        rem_sh       = {rem_reg, 1'b0};
        mrem_sh      = {mrem_reg, mq_reg[MW-1]};
        sum_wide     = {1'b0, sum_reg} + (SW+1)'(term_reg);
        t_fin        = eq_reg ? (RW+1)'(1) << RW : t_reg;
        usq          = u_reg * u_reg;
        prod_rnd     = prod_reg + (65'd1 << (gop_pkg::ROUND_SH - 1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd      = 1'b1;
                    work_next = q_work;
                    if (q_work.is_neighbour && cnt_reg < CNT_W'(MAX_NEIGHBOURS))
                    begin
                        px_next    = '0;
                        py_next    = '0;
                        iter_next  = '0;
                        state_next = S_PROJ;
                    end
                    else if (q_work.last_of_atom)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_PROJ:
            begin
                if (iter_reg < 5'd3)
                begin
                    px_next = px_reg + {{(PW-48){mprod[47]}}, mprod};
                end
                else
                begin
                    py_next = py_reg + {{(PW-48){mprod[47]}}, mprod};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 5'd5)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                ax_next      = px_reg[PW-1] ? PW'(-px_reg) : PW'(px_reg);
                ay_next      = py_reg[PW-1] ? PW'(-py_reg) : PW'(py_reg);
                shifted_next = 1'b0;
                state_next   = S_NORM;
            end
            S_NORM:
            begin
                // shift both together until each is below 2^31
                if (ax_reg[PW-1:31] != '0 || ay_reg[PW-1:31] != '0)
                begin
                    ax_next      = ax_reg >> 1;
                    ay_next      = ay_reg >> 1;
                    shifted_next = 1'b1;
                end
                else
                begin
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                a2_next    = ax_reg[30:0] * ax_reg[30:0];
                state_next = S_SQB;
            end
            S_SQB:
            begin
                den_next   = {1'b0, a2_reg} + 63'(ay_reg[30:0] * ay_reg[30:0]);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!shifted_reg && 64'(den_reg) < gop_pkg::NEAR_ZERO_Q60)
                begin
                    term_next  = TW'(1) << gop_pkg::FRACTION_BITS;
                    state_next = S_ACC;
                end
                else
                begin
                    eq_next    = (63'(a2_reg) == den_reg);
                    rem_next   = 64'(a2_reg);
                    t_next     = '0;
                    iter_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_sh >= 65'(den_reg))
                begin
                    rem_next = 64'(rem_sh - 65'(den_reg));
                    t_next   = {t_reg[RW-1:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[63:0];
                    t_next   = {t_reg[RW-1:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 5'(RW - 1))
                begin
                    state_next = S_U;
                end
            end
            S_U:
            begin
                t_next     = t_fin;
                u_next     = 32'hC000_0000 - {t_fin, 1'b0};
                state_next = S_USQ;
            end
            S_USQ:
            begin
                u2_next    = 34'((usq + (64'd1 << (RW - 1))) >> RW);
                state_next = S_PRD;
            end
            S_PRD:
            begin
                prod_next  = 65'(u2_reg * t_reg);
                state_next = S_RND;
            end
            S_RND:
            begin
                term_next  = prod_rnd[gop_pkg::ROUND_SH +: TW];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next   = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
                cnt_next   = cnt_reg + 1'b1;
                state_next = work_reg.last_of_atom ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (cnt_reg == '0)
                begin
                    value_next = prev_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    mq_next    = {1'b0, sum_reg} + MW'(cnt_reg >> 1);
                    mrem_next  = '0;
                    iter_next  = '0;
                    state_next = S_MDIV;
                end
            end
            S_MDIV:
            begin
                // restoring divide of the rounded sum by the count
                if (mrem_sh >= {1'b0, cnt_reg})
                begin
                    mrem_next = CNT_W'(mrem_sh - {1'b0, cnt_reg});
                    mq_next   = {mq_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    mrem_next = mrem_sh[CNT_W-1:0];
                    mq_next   = {mq_reg[MW-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 5'(MW - 1))
                begin
                    value_next = mq_next[VW-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_full)
                begin
                    out_wr     = 1'b1;
                    prev_next  = value_reg;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_result.orientation_value = value_reg;
        out_result.grain_id          = (value_reg > grain_cut);
        out_result.neighbour_total   = 8'(cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg    <= iter_next;
        work_reg    <= work_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        shifted_reg <= shifted_next;
        a2_reg      <= a2_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        t_reg       <= t_next;
        eq_reg      <= eq_next;
        u_reg       <= u_next;
        u2_reg      <= u2_next;
        prod_reg    <= prod_next;
        term_reg    <= term_next;
        mq_reg      <= mq_next;
        mrem_reg    <= mrem_next;
        value_reg   <= value_next;
    end

endmodule

/* sv/grain_orientation_parameter_unit.sv */
// ----------------------------------------------------------------------------
// grain_orientation_parameter_unit
// Orientation order parameter of one atom from its neighbour offsets.
// ----------------------------------------------------------------------------
// neighbour request: handled in the back sequencer (6 projection products, up to
//   17 normalize shifts, then, unless the projection is near zero, the
//   30-step c^2 divider and multiplies)
// last request may add the 27-step mean divider; one at a time
// a 4-deep input queue and a 4-deep result queue decouple both sides
// reset: configuration to defaults, sum, count and previous value cleared
module grain_orientation_parameter_unit #(
    parameter int MAX_NEIGHBOURS = gop_pkg::DEFAULT_MAX_NEIGHBOURS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  gop_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output gop_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [gop_pkg::CFG_W-1:0] cfg_data
);

    logic [30:0]                 box_x_reg, box_y_reg, box_z_reg;
    logic [47:0]                 x_coeffs_reg, y_coeffs_reg;
    logic [gop_pkg::VALUE_W-1:0] cut_reg;

    logic             q_wr, q_full, q_rd, q_empty;
    gop_pkg::work_t   q_in, q_out;
    logic             r_wr, r_full;
    gop_pkg::result_t r_in, r_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg    <= gop_pkg::BOX_RESET;
            box_y_reg    <= gop_pkg::BOX_RESET;
            box_z_reg    <= gop_pkg::BOX_RESET;
            x_coeffs_reg <= gop_pkg::X_COEFFS_RESET;
            y_coeffs_reg <= gop_pkg::Y_COEFFS_RESET;
            cut_reg      <= gop_pkg::CUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gop_pkg::REG_BOX_X:     box_x_reg    <= cfg_data[30:0];
                gop_pkg::REG_BOX_Y:     box_y_reg    <= cfg_data[30:0];
                gop_pkg::REG_BOX_Z:     box_z_reg    <= cfg_data[30:0];
                gop_pkg::REG_X_COEFFS:  x_coeffs_reg <= cfg_data[47:0];
                gop_pkg::REG_Y_COEFFS:  y_coeffs_reg <= cfg_data[47:0];
                gop_pkg::REG_GRAIN_CUT: cut_reg      <= cfg_data[gop_pkg::VALUE_W-1:0];
                default:                ;
            endcase
        end
    end

    assign full = q_full;

    gop_front u_front (
        .push   (push),
        .q_full (q_full),
        .item   (item),
        .box_x  (box_x_reg),
        .box_y  (box_y_reg),
        .box_z  (box_z_reg),
        .q_wr   (q_wr),
        .q_work (q_in)
    );

    gop_fifo #(
        .WIDTH ($bits(gop_pkg::work_t)),
        .DEPTH (gop_pkg::QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_in),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_out),
        .empty (q_empty)
    );

    gop_back #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_work     (q_out),
        .q_rd       (q_rd),
        .x_coeffs   (x_coeffs_reg),
        .y_coeffs   (y_coeffs_reg),
        .grain_cut  (cut_reg),
        .out_full   (r_full),
        .out_wr     (r_wr),
        .out_result (r_in)
    );

    gop_fifo #(
        .WIDTH ($bits(gop_pkg::result_t)),
        .DEPTH (gop_pkg::QUEUE_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (r_wr),
        .wdata (r_in),
        .full  (r_full),
        .rd    (pop),
        .rdata (r_out),
        .empty (empty)
    );

    assign result = r_out;

endmodule
